@@ rtl/gcd_pkg.sv @@
// Shared types, widths and elaboration-time constants for the great circle core.
// Holds the arctangent table and inverse gain builders used by the CORDIC cells.
// No dependencies.
package gcd_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STAGES = 24;
  localparam int ANG_FRAC      = 32;
  localparam int VEC_FRAC      = 30;
  localparam int ANG_W         = 44;
  localparam int VEC_W         = 34;
  localparam int SUM_W         = 32;
  localparam int SQ_W          = 64;
  localparam int SQRT_STEPS    = 32;
  localparam int SHIFT_W       = $clog2(CORDIC_STAGES);
  localparam int LAT_W         = 24;
  localparam int LON_W         = 25;
  localparam int DIST_W        = 30;
  localparam int NM_PER_DEG    = 60;
  localparam int HALF_TURN     = 180;
  localparam int OUT_SHIFT     = ANG_FRAC - FRAC_BITS;
  localparam int NM_W          = ANG_W + 7;

  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic signed [VEC_W-1:0] vec_t;

  typedef struct packed {
    logic adv;
    logic vld;
  } ctl_t;

  localparam logic [63:0] PI4_Q62 = 64'h3243F6A8885A308D;

  localparam ang_t LAT_LIM = ang_t'(64'(90) << FRAC_BITS);
  localparam ang_t LON_LIM = ang_t'(64'(HALF_TURN) << FRAC_BITS);
  localparam ang_t DEG90   = ang_t'(64'(90) << ANG_FRAC);
  localparam ang_t DEG180  = ang_t'(64'(HALF_TURN) << ANG_FRAC);
  localparam ang_t DEG360  = ang_t'(64'(2 * HALF_TURN) << ANG_FRAC);

  // shift-subtract division, elaboration only
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] stp;
    v   = v_in;
    res = '0;
    stp = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (v >= res + stp) begin
        v   = v - (res + stp);
        res = (res >> 1) + stp;
      end else begin
        res = res >> 1;
      end
      stp = stp >> 2;
    end
    return res;
  endfunction

  // atan(2^-i) in degrees with ANG_FRAC fraction bits
  function automatic logic [63:0] atan_deg(input int i);
    logic [63:0] rad;
    logic [63:0] rem;
    logic [63:0] q;
    logic [63:0] term;
    if (i == 0) begin
      rad = PI4_Q62;
    end else begin
      rad = '0;
      for (int k = 0; k < 32; k++) begin
        if (i * (2 * k + 1) <= 62) begin
          term = udiv(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1));
          if (k[0]) begin
            rad = rad - term;
          end else begin
            rad = rad + term;
          end
        end
      end
    end
    rem = rad;
    q   = '0;
    if (rem >= PI4_Q62) begin
      rem = rem - PI4_Q62;
      q   = 64'd1;
    end
    for (int n = 0; n < 40; n++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= PI4_Q62) begin
        rem  = rem - PI4_Q62;
        q[0] = 1'b1;
      end
    end
    return (q * 64'd45 + 64'd128) >> 8;
  endfunction

  function automatic logic [63:0] inv_gain();
    logic [63:0] p;
    logic [63:0] kq;
    p = 64'd1 << VEC_FRAC;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      p = p + (p >> (2 * i));
    end
    kq = isqrt(p << VEC_FRAC);
    if (kq == 64'd0) begin
      kq = 64'd1;
    end
    return udiv((64'd1 << (2 * VEC_FRAC)) + (kq >> 1), kq);
  endfunction

  localparam vec_t INV_GAIN = vec_t'(inv_gain());

endpackage

@@ rtl/great_circle_distance_core.sv @@
// Great circle distance core: spherical law of cosines over CORDIC cell chains.
// Takes one word per cycle while the output word is not waiting.
// Each cell in the chains finishes one step per cycle while the pipeline advances.
// The whole pipeline holds while the output word waits; in_ready follows that.
// Reset (rst_n low, synchronous) empties every stage; no clearing pass is needed.
// Depends on gcd_pkg, gcd_cordic_cell, gcd_sqrt_cell.
module great_circle_distance_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [gcd_pkg::LAT_W-1:0]  in_lat_a,
  input  logic signed [gcd_pkg::LON_W-1:0]  in_lon_a,
  input  logic signed [gcd_pkg::LAT_W-1:0]  in_lat_b,
  input  logic signed [gcd_pkg::LON_W-1:0]  in_lon_b,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gcd_pkg::DIST_W-1:0]        out_dist_nm
);

  localparam int N  = gcd_pkg::CORDIC_STAGES;
  localparam int NS = gcd_pkg::SQRT_STEPS;
  localparam int PW = 2 * gcd_pkg::VEC_W;

  // Global advance: every stage moves when the output register can take a word.
  logic adv;
  assign adv      = ~out_valid | out_ready;
  assign in_ready = adv;

  // ---------------------------------------------------------------------------
  // Stage 0: saturate the angles, scale to the internal angle format, take
  // the longitude difference.
  // ---------------------------------------------------------------------------
  gcd_pkg::ang_t la_w, lb_w, oa_w, ob_w;
  gcd_pkg::ang_t lat_a0_r, lat_b0_r, dlon0_r;
  logic          vld0_r;

  function automatic gcd_pkg::ang_t sat_scale(input gcd_pkg::ang_t v, input gcd_pkg::ang_t lim);
    gcd_pkg::ang_t s;
    s = v;
    if (s > lim) begin
      s = lim;
    end
    if (s < -lim) begin
      s = -lim;
    end
    return s <<< gcd_pkg::OUT_SHIFT;
  endfunction

  always_comb begin
    la_w = sat_scale(gcd_pkg::ang_t'(in_lat_a), gcd_pkg::LAT_LIM);
    lb_w = sat_scale(gcd_pkg::ang_t'(in_lat_b), gcd_pkg::LAT_LIM);
    oa_w = sat_scale(gcd_pkg::ang_t'(in_lon_a), gcd_pkg::LON_LIM);
    ob_w = sat_scale(gcd_pkg::ang_t'(in_lon_b), gcd_pkg::LON_LIM);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (adv) begin
      vld0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lat_a0_r <= la_w;
      lat_b0_r <= lb_w;
      dlon0_r  <= ob_w - oa_w;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: wrap the difference into a half turn, fold beyond a quarter turn.
  // The folded cosine is negated after the rotation chain.
  // ---------------------------------------------------------------------------
  gcd_pkg::ang_t dw_w, ad_w, dz_w;
  logic          fold_w;
  gcd_pkg::ang_t lat_a1_r, lat_b1_r, dz1_r;
  logic          fold1_r, vld1_r;

  always_comb begin
    dw_w = dlon0_r;
    if (dw_w > gcd_pkg::DEG180) begin
      dw_w = dw_w - gcd_pkg::DEG360;
    end
    if (dw_w < -gcd_pkg::DEG180) begin
      dw_w = dw_w + gcd_pkg::DEG360;
    end
    ad_w   = dw_w[gcd_pkg::ANG_W-1] ? -dw_w : dw_w;
    fold_w = ad_w > gcd_pkg::DEG90;
    dz_w   = fold_w ? gcd_pkg::DEG180 - ad_w : ad_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= vld0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lat_a1_r <= lat_a0_r;
      lat_b1_r <= lat_b0_r;
      dz1_r    <= dz_w;
      fold1_r  <= fold_w;
    end
  end

  // ---------------------------------------------------------------------------
  // Rotation chain: three rotators side by side, one cell each per step.
  // Lane a carries the valid bit for the row.
  // ---------------------------------------------------------------------------
  gcd_pkg::vec_t ax [N+1];
  gcd_pkg::vec_t ay [N+1];
  gcd_pkg::ang_t az [N+1];
  gcd_pkg::vec_t bx [N+1];
  gcd_pkg::vec_t by [N+1];
  gcd_pkg::ang_t bz [N+1];
  gcd_pkg::vec_t dx [N+1];
  gcd_pkg::vec_t dy [N+1];
  gcd_pkg::ang_t dz [N+1];
  logic          rv [N+1];
  logic          fold_q [N];

  assign ax[0] = gcd_pkg::INV_GAIN;
  assign ay[0] = '0;
  assign az[0] = lat_a1_r;
  assign bx[0] = gcd_pkg::INV_GAIN;
  assign by[0] = '0;
  assign bz[0] = lat_b1_r;
  assign dx[0] = gcd_pkg::INV_GAIN;
  assign dy[0] = '0;
  assign dz[0] = dz1_r;
  assign rv[0] = vld1_r;

  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam gcd_pkg::ang_t ATAN_C = gcd_pkg::ang_t'(gcd_pkg::atan_deg(i));
    localparam logic [gcd_pkg::SHIFT_W-1:0] SH = gcd_pkg::SHIFT_W'(i);
    gcd_pkg::ctl_t ctl;
    assign ctl.adv = adv;
    assign ctl.vld = rv[i];

    gcd_cordic_cell u_a (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .vec_mode(1'b0), .shift(SH), .atan_c(ATAN_C),
      .x_in(ax[i]), .y_in(ay[i]), .z_in(az[i]),
      .vld_out(rv[i+1]), .x_out(ax[i+1]), .y_out(ay[i+1]), .z_out(az[i+1])
    );
    gcd_cordic_cell u_b (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .vec_mode(1'b0), .shift(SH), .atan_c(ATAN_C),
      .x_in(bx[i]), .y_in(by[i]), .z_in(bz[i]),
      .vld_out(), .x_out(bx[i+1]), .y_out(by[i+1]), .z_out(bz[i+1])
    );
    gcd_cordic_cell u_d (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .vec_mode(1'b0), .shift(SH), .atan_c(ATAN_C),
      .x_in(dx[i]), .y_in(dy[i]), .z_in(dz[i]),
      .vld_out(), .x_out(dx[i+1]), .y_out(dy[i+1]), .z_out(dz[i+1])
    );
  end

  // carry the fold flag alongside the rotation chain
  always_ff @(posedge clk) begin
    if (adv) begin
      fold_q[0] <= fold1_r;
      for (int k = 1; k < N; k++) begin
        fold_q[k] <= fold_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Products: S = sa*sb + ((ca*cb) >>> 30) * cd, rounded to Q30 and clamped.
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] ss_w, cc_w, p3_w, s3_w, sh3_w;
  logic signed [PW-1:0] ss1_r, cc1_r, ss2_r, p3_r;
  gcd_pkg::vec_t        cd1_r, q2_w;
  logic                 vm1_r, vm2_r, vm3_r;
  logic signed [gcd_pkg::SUM_W-1:0] sum3_r, sum_w;

  localparam logic signed [PW-1:0] RND_Q  = PW'(64'd1 << (gcd_pkg::VEC_FRAC - 1));
  localparam logic signed [PW-1:0] ONE_P  = PW'(64'd1 << gcd_pkg::VEC_FRAC);

  assign ss_w = ay[N] * by[N];
  assign cc_w = ax[N] * bx[N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm1_r <= 1'b0;
      vm2_r <= 1'b0;
      vm3_r <= 1'b0;
    end else if (adv) begin
      vm1_r <= rv[N];
      vm2_r <= vm1_r;
      vm3_r <= vm2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ss1_r <= ss_w;
      cc1_r <= cc_w;
      cd1_r <= fold_q[N-1] ? -dx[N] : dx[N];
    end
  end

  assign q2_w = gcd_pkg::vec_t'(cc1_r >>> gcd_pkg::VEC_FRAC);
  assign p3_w = q2_w * cd1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ss2_r <= ss1_r;
      p3_r  <= p3_w;
    end
  end

  always_comb begin
    s3_w  = ss2_r + p3_r + RND_Q;
    sh3_w = s3_w >>> gcd_pkg::VEC_FRAC;
    if (sh3_w > ONE_P) begin
      sum_w = gcd_pkg::SUM_W'(ONE_P);
    end else if (sh3_w < -ONE_P) begin
      sum_w = gcd_pkg::SUM_W'(-ONE_P);
    end else begin
      sum_w = gcd_pkg::SUM_W'(sh3_w);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum3_r <= sum_w;
    end
  end

  // ---------------------------------------------------------------------------
  // Square and radicand: v = 1 - S^2 in Q60.
  // ---------------------------------------------------------------------------
  logic signed [2*gcd_pkg::SUM_W-1:0] sq_w;
  logic [gcd_pkg::SQ_W-1:0]           sq4_r, v5_r;
  gcd_pkg::vec_t                      abs4_r, abs5_r;
  logic                               neg4_r, neg5_r, vm4_r, vm5_r;

  assign sq_w = sum3_r * sum3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm4_r <= 1'b0;
      vm5_r <= 1'b0;
    end else if (adv) begin
      vm4_r <= vm3_r;
      vm5_r <= vm4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq4_r  <= gcd_pkg::SQ_W'(sq_w);
      abs4_r <= gcd_pkg::vec_t'(sum3_r[gcd_pkg::SUM_W-1] ? -sum3_r : sum3_r);
      neg4_r <= sum3_r[gcd_pkg::SUM_W-1];
      v5_r   <= (gcd_pkg::SQ_W'(1) << (2 * gcd_pkg::VEC_FRAC)) - sq4_r;
      abs5_r <= abs4_r;
      neg5_r <= neg4_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Square root chain: one restoring step per cell.
  // ---------------------------------------------------------------------------
  logic [gcd_pkg::SQ_W-1:0] sv [NS+1];
  logic [gcd_pkg::SQ_W-1:0] sr [NS+1];
  logic                     svl [NS+1];
  gcd_pkg::vec_t            abs_q [NS];
  logic                     neg_q [NS];

  assign sv[0]  = v5_r;
  assign sr[0]  = '0;
  assign svl[0] = vm5_r;

  for (genvar j = 0; j < NS; j++) begin : g_sqrt
    localparam logic [gcd_pkg::SQ_W-1:0] STEP = gcd_pkg::SQ_W'(1) << (62 - 2 * j);
    gcd_pkg::ctl_t ctl;
    assign ctl.adv = adv;
    assign ctl.vld = svl[j];

    gcd_sqrt_cell u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .step_c(STEP),
      .v_in(sv[j]), .res_in(sr[j]),
      .vld_out(svl[j+1]), .v_out(sv[j+1]), .res_out(sr[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      abs_q[0] <= abs5_r;
      neg_q[0] <= neg5_r;
      for (int k = 1; k < NS; k++) begin
        abs_q[k] <= abs_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Vectoring chain: t = atan2(root, |S|).
  // ---------------------------------------------------------------------------
  gcd_pkg::vec_t vx [N+1];
  gcd_pkg::vec_t vy [N+1];
  gcd_pkg::ang_t vz [N+1];
  logic          vv [N+1];
  logic          negv_q [N];

  assign vx[0] = abs_q[NS-1];
  assign vy[0] = gcd_pkg::vec_t'(sr[NS]);
  assign vz[0] = '0;
  assign vv[0] = svl[NS];

  for (genvar i = 0; i < N; i++) begin : g_vec
    localparam gcd_pkg::ang_t ATAN_C = gcd_pkg::ang_t'(gcd_pkg::atan_deg(i));
    localparam logic [gcd_pkg::SHIFT_W-1:0] SH = gcd_pkg::SHIFT_W'(i);
    gcd_pkg::ctl_t ctl;
    assign ctl.adv = adv;
    assign ctl.vld = vv[i];

    gcd_cordic_cell u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .vec_mode(1'b1), .shift(SH), .atan_c(ATAN_C),
      .x_in(vx[i]), .y_in(vy[i]), .z_in(vz[i]),
      .vld_out(vv[i+1]), .x_out(vx[i+1]), .y_out(vy[i+1]), .z_out(vz[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      negv_q[0] <= neg_q[NS-1];
      for (int k = 1; k < N; k++) begin
        negv_q[k] <= negv_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Arc: clamp t to a quarter turn, mirror for a negative sum.
  // ---------------------------------------------------------------------------
  gcd_pkg::ang_t t_w, arc_r;
  logic          vf_r;

  always_comb begin
    t_w = vz[N];
    if (t_w < 0) begin
      t_w = '0;
    end
    if (t_w > gcd_pkg::DEG90) begin
      t_w = gcd_pkg::DEG90;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (adv) begin
      vf_r <= vv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      arc_r <= negv_q[N-1] ? gcd_pkg::DEG180 - t_w : t_w;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: scale by 60 nautical miles per degree, round half up.
  // ---------------------------------------------------------------------------
  localparam logic [gcd_pkg::NM_W-1:0] NM_HALF =
    gcd_pkg::NM_W'(1) << (gcd_pkg::OUT_SHIFT - 1);

  logic [gcd_pkg::NM_W-1:0]   nm_w;
  logic [gcd_pkg::DIST_W-1:0] dist_nxt, dist_r;
  logic                       out_valid_r;

  assign nm_w     = gcd_pkg::NM_W'(arc_r) * gcd_pkg::NM_W'(gcd_pkg::NM_PER_DEG) + NM_HALF;
  assign dist_nxt = nm_w[gcd_pkg::OUT_SHIFT +: gcd_pkg::DIST_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vf_r;
    end
  end

  // hold the word while the consumer stalls
  always_ff @(posedge clk) begin
    if (adv) begin
      dist_r <= dist_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_dist_nm = dist_r;

endmodule

@@ rtl/gcd_cordic_cell.sv @@
// One CORDIC micro-rotation cell, rotation or vectoring mode.
// Depends on gcd_pkg.
module gcd_cordic_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gcd_pkg::ctl_t                ctl,
  input  logic                         vec_mode,
  input  logic [gcd_pkg::SHIFT_W-1:0]  shift,
  input  gcd_pkg::ang_t                atan_c,
  input  gcd_pkg::vec_t                x_in,
  input  gcd_pkg::vec_t                y_in,
  input  gcd_pkg::ang_t                z_in,
  output logic                         vld_out,
  output gcd_pkg::vec_t                x_out,
  output gcd_pkg::vec_t                y_out,
  output gcd_pkg::ang_t                z_out
);

  logic          vld_r;
  gcd_pkg::vec_t x_r, x_nxt, y_r, y_nxt, xs, ys;
  gcd_pkg::ang_t z_r, z_nxt;
  logic          dir;

  always_comb begin
    // rotation drives z toward zero, vectoring drives y toward zero
    dir = vec_mode ? y_in[gcd_pkg::VEC_W-1] : ~z_in[gcd_pkg::ANG_W-1];
    xs  = x_in >>> shift;
    ys  = y_in >>> shift;
    if (dir) begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - atan_c;
    end else begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + atan_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.adv) begin
      vld_r <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign vld_out = vld_r;
  assign x_out   = x_r;
  assign y_out   = y_r;
  assign z_out   = z_r;

endmodule

@@ rtl/gcd_sqrt_cell.sv @@
// One restoring step of the integer square root: one result bit from two radicand bits.
// Depends on gcd_pkg.
module gcd_sqrt_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gcd_pkg::ctl_t              ctl,
  input  logic [gcd_pkg::SQ_W-1:0]   step_c,
  input  logic [gcd_pkg::SQ_W-1:0]   v_in,
  input  logic [gcd_pkg::SQ_W-1:0]   res_in,
  output logic                       vld_out,
  output logic [gcd_pkg::SQ_W-1:0]   v_out,
  output logic [gcd_pkg::SQ_W-1:0]   res_out
);

  logic                     vld_r;
  logic [gcd_pkg::SQ_W-1:0] v_r, v_nxt, res_r, res_nxt, trial;

  always_comb begin
    trial = res_in + step_c;
    if (v_in >= trial) begin
      v_nxt   = v_in - trial;
      res_nxt = (res_in >> 1) + step_c;
    end else begin
      v_nxt   = v_in;
      res_nxt = res_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.adv) begin
      vld_r <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      v_r   <= v_nxt;
      res_r <= res_nxt;
    end
  end

  assign vld_out = vld_r;
  assign v_out   = v_r;
  assign res_out = res_r;

endmodule

@@ rtl/gcd_checker.sv @@
// Port-level checks for the great circle core, attached by bind.
// Depends on gcd_pkg and great_circle_distance_core.
module gcd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [gcd_pkg::DIST_W-1:0] out_dist_nm
);

  localparam logic [gcd_pkg::DIST_W-1:0] DIST_MAX =
    gcd_pkg::DIST_W'(64'(gcd_pkg::NM_PER_DEG * gcd_pkg::HALF_TURN) << gcd_pkg::FRAC_BITS);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word present right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_dist_nm))
    else $error("output word changed while stalled");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline is frozen");

  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_dist_nm <= DIST_MAX)
    else $error("distance beyond half circumference");

endmodule

bind great_circle_distance_core gcd_checker u_gcd_checker (.*);

@@ verif/tb_top.sv @@
// Self-checking testbench for great_circle_distance_core: predicts each distance
// from the point pair and checks every output word in order. Depends on gcd_pkg and great_circle_distance_core.
module tb_top;

  typedef struct {
    logic signed [gcd_pkg::LAT_W-1:0] lat_a;
    logic signed [gcd_pkg::LON_W-1:0] lon_a;
    logic signed [gcd_pkg::LAT_W-1:0] lat_b;
    logic signed [gcd_pkg::LON_W-1:0] lon_b;
  } pair_t;

  localparam longint DEG_LAT = longint'(90) << gcd_pkg::FRAC_BITS;
  localparam longint DEG_LON = longint'(gcd_pkg::HALF_TURN) << gcd_pkg::FRAC_BITS;
  localparam int     DRAIN_CYCLES = 2 * gcd_pkg::CORDIC_STAGES + 41 + 60;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [gcd_pkg::LAT_W-1:0] in_lat_a;
  logic signed [gcd_pkg::LON_W-1:0] in_lon_a;
  logic signed [gcd_pkg::LAT_W-1:0] in_lat_b;
  logic signed [gcd_pkg::LON_W-1:0] in_lon_b;
  logic out_valid;
  logic out_ready;
  logic [gcd_pkg::DIST_W-1:0] out_dist_nm;

  pair_t                      pending_pairs[$];
  logic [gcd_pkg::DIST_W-1:0] expected_dist[$];
  longint                     atan_tab[gcd_pkg::CORDIC_STAGES];
  longint                     rot_gain;
  int                errors;
  int                words_in;
  int                words_out;
  int                idle_pct;
  int                stall_pct;
  int                hold_cycles;
  logic              in_fire;

  great_circle_distance_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_lat_a   (in_lat_a),
    .in_lon_a   (in_lon_a),
    .in_lat_b   (in_lat_b),
    .in_lon_b   (in_lon_b),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_dist_nm(out_dist_nm)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Distance predictor: integer-only CORDIC, same truncation rules as the core.
  // ---------------------------------------------------------------------------
  function automatic longint unsigned int_sqrt(input longint unsigned v_in);
    longint unsigned v;
    longint unsigned root;
    longint unsigned stp;
    v    = v_in;
    root = 0;
    stp  = 64'd1 << 62;
    while (stp > v) stp = stp >> 2;
    while (stp != 0) begin
      if (v >= root + stp) begin
        v    = v - (root + stp);
        root = (root >> 1) + stp;
      end else begin
        root = root >> 1;
      end
      stp = stp >> 2;
    end
    return root;
  endfunction

  // atan(2^-i) in degrees, 32 fraction bits
  function automatic longint atan_degrees(input int i);
    longint unsigned rad;
    longint unsigned rem;
    longint unsigned q;
    longint unsigned term;
    int k;
    if (i == 0) begin
      rad = gcd_pkg::PI4_Q62;
    end else begin
      rad = 0;
      k   = 0;
      while (i * (2 * k + 1) <= 62) begin
        term = (64'd1 << (62 - i * (2 * k + 1))) / longint'(2 * k + 1);
        if (k % 2 == 1) rad = rad - term;
        else rad = rad + term;
        k++;
      end
    end
    rem = rad;
    q   = 0;
    if (rem >= gcd_pkg::PI4_Q62) begin
      rem = rem - gcd_pkg::PI4_Q62;
      q   = 1;
    end
    for (int n = 0; n < 40; n++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= gcd_pkg::PI4_Q62) begin
        rem = rem - gcd_pkg::PI4_Q62;
        q   = q | 1;
      end
    end
    return longint'((q * 45 + 128) >> 8);
  endfunction

  task automatic build_cordic_consts();
    longint unsigned p;
    longint unsigned kq;
    p = 64'd1 << gcd_pkg::VEC_FRAC;
    for (int i = 0; i < gcd_pkg::CORDIC_STAGES; i++) begin
      atan_tab[i] = atan_degrees(i);
      p = p + (p >> (2 * i));
    end
    kq = int_sqrt(p << gcd_pkg::VEC_FRAC);
    if (kq == 0) kq = 1;
    rot_gain = longint'(((64'd1 << (2 * gcd_pkg::VEC_FRAC)) + kq / 2) / kq);
  endtask

  function automatic void rotate(input longint ang, output longint c, output longint s);
    longint x;
    longint y;
    longint z;
    longint nx;
    x = rot_gain;
    y = 0;
    z = ang;
    for (int i = 0; i < gcd_pkg::CORDIC_STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_tab[i];
      end
      x = nx;
    end
    c = x;
    s = y;
  endfunction

  function automatic longint vector_angle(input longint x_in, input longint y_in);
    longint x;
    longint y;
    longint z;
    longint nx;
    x = x_in;
    y = y_in;
    z = 0;
    for (int i = 0; i < gcd_pkg::CORDIC_STAGES; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_tab[i];
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_tab[i];
      end
      x = nx;
    end
    return z;
  endfunction

  // saturate to +/-limit, then widen to 32 fraction bits
  function automatic longint widen_angle(input longint v_in, input longint limit);
    longint v;
    v = v_in;
    if (v > limit) v = limit;
    if (v < -limit) v = -limit;
    return v <<< (gcd_pkg::ANG_FRAC - gcd_pkg::FRAC_BITS);
  endfunction

  function automatic logic [gcd_pkg::DIST_W-1:0] predict_dist(input pair_t w);
    longint one;
    longint deg90;
    longint deg180;
    longint la;
    longint lb;
    longint d;
    longint ad;
    longint ca, sa, cb, sb, cd, sd;
    longint acc;
    longint sum;
    longint root;
    longint t;
    longint arc;
    longint nm;
    one    = longint'(1) << gcd_pkg::VEC_FRAC;
    deg90  = longint'(90) << gcd_pkg::ANG_FRAC;
    deg180 = longint'(gcd_pkg::HALF_TURN) << gcd_pkg::ANG_FRAC;
    la = widen_angle(longint'(w.lat_a), DEG_LAT);
    lb = widen_angle(longint'(w.lat_b), DEG_LAT);
    d  = widen_angle(longint'(w.lon_b), DEG_LON) - widen_angle(longint'(w.lon_a), DEG_LON);
    rotate(la, ca, sa);
    rotate(lb, cb, sb);
    // wrap the longitude difference, fold beyond 90 degrees
    if (d > deg180) d = d - 2 * deg180;
    if (d < -deg180) d = d + 2 * deg180;
    ad = (d < 0) ? -d : d;
    if (ad <= deg90) begin
      rotate(ad, cd, sd);
    end else begin
      rotate(deg180 - ad, cd, sd);
      cd = -cd;
    end
    acc = sa * sb + ((ca * cb) >>> gcd_pkg::VEC_FRAC) * cd;
    sum = (acc + (longint'(1) << (gcd_pkg::VEC_FRAC - 1))) >>> gcd_pkg::VEC_FRAC;
    if (sum > one) sum = one;
    if (sum < -one) sum = -one;
    root = longint'(int_sqrt(longint'(one * one - sum * sum)));
    t = vector_angle((sum < 0) ? -sum : sum, root);
    if (t < 0) t = 0;
    if (t > deg90) t = deg90;
    arc = (sum >= 0) ? t : deg180 - t;
    nm  = (arc * gcd_pkg::NM_PER_DEG + (longint'(1) << (gcd_pkg::OUT_SHIFT - 1)))
          >>> gcd_pkg::OUT_SHIFT;
    return nm[gcd_pkg::DIST_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("MISMATCH at %0t: %s expected %0d got %0d", $time, what, want, got);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: advance to the next word at the falling edge once the current one
  // was taken; hold valid and payload steady otherwise.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    pair_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_pairs.size() > 0 && $urandom_range(99) >= idle_pct) begin
        w = pending_pairs.pop_front();
        in_valid <= 1'b1;
        in_lat_a <= w.lat_a;
        in_lon_a <= w.lon_a;
        in_lat_b <= w.lat_b;
        in_lon_b <= w.lon_b;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a forced hold-off while hold_cycles runs.
  always @(negedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  always @(negedge clk) begin
    if (!rst_n || hold_cycles > 0) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on accepted input words, check accepted output words.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pair_t w;
    logic [gcd_pkg::DIST_W-1:0] want;
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      w.lat_a = in_lat_a;
      w.lon_a = in_lon_a;
      w.lat_b = in_lat_b;
      w.lon_b = in_lon_b;
      expected_dist.push_back(predict_dist(w));
      words_in++;
    end
    if (rst_n && out_valid && out_ready) begin
      words_out++;
      if (expected_dist.size() == 0) begin
        report_mismatch("unexpected word, dist_nm", -1, longint'(out_dist_nm));
      end else begin
        want = expected_dist.pop_front();
        if (out_dist_nm !== want) report_mismatch("dist_nm", longint'(want), longint'(out_dist_nm));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic longint rand_field(input int width, input longint limit);
    int mode;
    longint full;
    mode = $urandom_range(99);
    full = longint'(1) << width;
    if (mode < 80) return longint'($urandom_range(0, 2 * limit)) - limit;
    if (mode < 92) return longint'($urandom % full) - full / 2;   // any bit pattern
    case ($urandom_range(3))
      0: return limit;
      1: return -limit;
      2: return limit - longint'($urandom_range(3));
      default: return -limit + longint'($urandom_range(3));
    endcase
  endfunction

  task automatic push_pair(input longint la, input longint oa, input longint lb, input longint ob);
    pair_t w;
    w.lat_a = la[gcd_pkg::LAT_W-1:0];
    w.lon_a = oa[gcd_pkg::LON_W-1:0];
    w.lat_b = lb[gcd_pkg::LAT_W-1:0];
    w.lon_b = ob[gcd_pkg::LON_W-1:0];
    pending_pairs.push_back(w);
  endtask

  task automatic push_random(input int n);
    longint la;
    longint oa;
    for (int i = 0; i < n; i++) begin
      la = rand_field(gcd_pkg::LAT_W, DEG_LAT);
      oa = rand_field(gcd_pkg::LON_W, DEG_LON);
      // drop in near-identical and near-antipodal pairs now and then
      case ($urandom_range(9))
        0: push_pair(la, oa, la + $urandom_range(2), oa - $urandom_range(2));
        1: push_pair(la, oa, -la, oa + ((oa < 0) ? DEG_LON : -DEG_LON));
        default: push_pair(la, oa, rand_field(gcd_pkg::LAT_W, DEG_LAT),
                           rand_field(gcd_pkg::LON_W, DEG_LON));
      endcase
    end
  endtask

  // wait until every queued pair has been sent and every expected word has come back
  task automatic wait_drained();
    while (pending_pairs.size() > 0 || in_valid || expected_dist.size() > 0) @(posedge clk);
  endtask

  task automatic run_phase(input int idle, input int stall, input int n);
    idle_pct  = idle;
    stall_pct = stall;
    push_random(n);
    wait_drained();
  endtask

  initial begin
    longint lat_max;
    longint lon_max;
    longint dg;
    lat_max     = (longint'(1) << (gcd_pkg::LAT_W - 1)) - 1;
    lon_max     = (longint'(1) << (gcd_pkg::LON_W - 1)) - 1;
    dg          = longint'(1) << gcd_pkg::FRAC_BITS;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    out_ready   = 1'b0;
    in_lat_a    = '0;
    in_lon_a    = '0;
    in_lat_b    = '0;
    in_lon_b    = '0;
    in_fire     = 1'b0;
    errors      = 0;
    words_in    = 0;
    words_out   = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_cycles = 0;
    build_cordic_consts();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: identical points, antipodes, poles, field extremes, saturation,
    // longitude wrap across the date line, differences past a quarter turn
    push_pair(0, 0, 0, 0);
    push_pair(0, 0, 0, DEG_LON);
    push_pair(0, -DEG_LON, 0, DEG_LON);
    push_pair(DEG_LAT, 0, -DEG_LAT, 0);
    push_pair(DEG_LAT, 12345, DEG_LAT, -DEG_LON);
    push_pair(-DEG_LAT, 0, -DEG_LAT, 0);
    push_pair(lat_max, lon_max, -lat_max - 1, -lon_max - 1);
    push_pair(-lat_max - 1, -lon_max - 1, lat_max, lon_max);
    push_pair(DEG_LAT + 1, DEG_LON + 1, -DEG_LAT - 1, -DEG_LON - 1);
    push_pair(0, 170 * dg, 0, -(170 * dg));
    push_pair(0, -(179 * dg), 0, 179 * dg);
    push_pair(30 * dg, 0, 30 * dg, 91 * dg);
    push_pair(0, 0, 0, 90 * dg);
    push_pair(0, 0, 0, (90 * dg) + 1);
    push_pair(45 * dg, 10 * dg, -(45 * dg), -(170 * dg));
    push_pair(1, 0, 0, 1);
    push_pair(lat_max, 0, 0, lon_max);
    push_pair(-1, -1, -1, -1);
    push_pair(51 * dg, 0, 40 * dg, -(74 * dg));
    push_pair(-(33 * dg), 151 * dg, 35 * dg, 139 * dg);
    wait_drained();

    run_phase(0, 0, 320);
    run_phase(88, 0, 220);
    run_phase(0, 88, 220);
    run_phase(10, 10, 320);

    // hold the receiver off long enough to fill the pipe and back up the input
    idle_pct  = 0;
    stall_pct = 0;
    @(negedge clk);
    hold_cycles <= 400;
    push_random(250);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    while (expected_dist.size() > 0) begin
      report_mismatch("missing word, dist_nm", longint'(expected_dist.pop_front()), -1);
    end
    $display("Covered %0d point pairs in, %0d distances out, across free-running,",
             words_in, words_out);
    $display("sparse-sender, stalled-receiver, mixed and long back-pressure phases.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #5000000;
    $display("Timeout: %0d words still expected", expected_dist.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
